// File: hw/rtl/dtq_pkg.sv
// Package for the deadline timer queue: operation codes, result kinds,
// timer status codes, sizing constants and the chain command. Depends on nothing.
package dtq_pkg;

    localparam int NumTimersDefault = 16;
    localparam int IdWidth = 4;
    localparam int TimeWidth = 64;

    typedef enum logic [1:0] {
        OP_SET      = 2'd0,
        OP_INSTALL  = 2'd1,
        OP_CANCEL   = 2'd2,
        OP_PROGRESS = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_FIRED   = 2'd0,
        KIND_ARM     = 2'd1,
        KIND_ACK     = 2'd2,
        KIND_IGNORED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_UNUSED    = 2'd0,
        ST_QUEUED    = 2'd1,
        ST_FIRED     = 2'd2,
        ST_CANCELLED = 2'd3
    } status_t;

    // Chain command that every cell sees in the same cycle.
    typedef struct packed {
        logic                 insert;
        logic                 remove;
        logic                 pop;
        logic [IdWidth-1:0]   id;
        logic [TimeWidth-1:0] key;
    } chain_cmd_t;

endpackage

// File: hw/rtl/dtq_cell.sv
// One cell of the sorted chain: holds one queued timer and its deadline.
// Depends on dtq_pkg.
module dtq_cell
    import dtq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  chain_cmd_t           cmd,
    input  logic                 left_valid,
    input  logic [IdWidth-1:0]   left_id,
    input  logic [TimeWidth-1:0] left_key,
    input  logic                 left_before,
    input  logic                 left_match,
    input  logic                 right_valid,
    input  logic [IdWidth-1:0]   right_id,
    input  logic [TimeWidth-1:0] right_key,
    output logic                 valid,
    output logic [IdWidth-1:0]   id,
    output logic [TimeWidth-1:0] key,
    output logic                 ahead,
    output logic                 match
);

    logic                 valid_reg, valid_next;
    logic [IdWidth-1:0]   id_reg, id_next;
    logic [TimeWidth-1:0] key_reg, key_next;

    // Flags: ahead says this cell holds an entry that goes before the new one;
    // match says this cell or one to its left holds the id being removed.
    logic here_before;
    assign here_before = valid_reg && ((key_reg < cmd.key) ||
                         (key_reg == cmd.key && id_reg < cmd.id));
    assign ahead = here_before;
    assign match = left_match || (valid_reg && id_reg == cmd.id);

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        key_next   = key_reg;
        if (cmd.pop || (cmd.remove && match))
        begin
            valid_next = right_valid;
            id_next    = right_id;
            key_next   = right_key;
        end
        else if (cmd.insert && !here_before)
        begin
            if (left_before)
            begin
                valid_next = 1'b1;
                id_next    = cmd.id;
                key_next   = cmd.key;
            end
            else
            begin
                valid_next = left_valid;
                id_next    = left_id;
                key_next   = left_key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        key_reg <= key_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign key   = key_reg;

endmodule

// File: hw/rtl/dtq_chain.sv
// Row of sorting cells kept in order of deadline then timer index.
// Depends on dtq_pkg and dtq_cell.
module dtq_chain
    import dtq_pkg::*;
#(
    parameter int NUM_TIMERS = NumTimersDefault
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  chain_cmd_t           cmd,
    output logic                 head_valid,
    output logic [IdWidth-1:0]   head_id,
    output logic [TimeWidth-1:0] head_key
);

    logic                 v   [NUM_TIMERS+1];
    logic [IdWidth-1:0]   ids [NUM_TIMERS+1];
    logic [TimeWidth-1:0] ks  [NUM_TIMERS+1];
    logic                 bf  [NUM_TIMERS+1];
    logic                 mt  [NUM_TIMERS+1];

    // Position zero is the left boundary: the new entry goes first there.
    assign bf[0] = 1'b1;
    assign mt[0] = 1'b0;
    assign v[0]  = 1'b0;
    assign ids[0] = '0;
    assign ks[0]  = '0;

    logic                 rv   [NUM_TIMERS];
    logic [IdWidth-1:0]   rids [NUM_TIMERS];
    logic [TimeWidth-1:0] rks  [NUM_TIMERS];

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_cell
        if (i == NUM_TIMERS - 1)
        begin : g_end
            assign rv[i]   = 1'b0;
            assign rids[i] = '0;
            assign rks[i]  = '0;
        end
        else
        begin : g_mid
            assign rv[i]   = v[i+2];
            assign rids[i] = ids[i+2];
            assign rks[i]  = ks[i+2];
        end
        dtq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_valid  (v[i]),
            .left_id     (ids[i]),
            .left_key    (ks[i]),
            .left_before (bf[i]),
            .left_match  (mt[i]),
            .right_valid (rv[i]),
            .right_id    (rids[i]),
            .right_key   (rks[i]),
            .valid       (v[i+1]),
            .id          (ids[i+1]),
            .key         (ks[i+1]),
            .ahead       (bf[i+1]),
            .match       (mt[i+1])
        );
    end

    assign head_valid = v[1];
    assign head_id    = ids[1];
    assign head_key   = ks[1];

endmodule

// File: hw/rtl/deadline_timer_queue.sv
// Set, install and cancel: one result each; a new beat may follow once the output
// register is free. Progress: after the beat is taken, one fired result per cycle
// from the chain head while the output is not stalled, then the arm beat.
// Reset empties the chain, marks every timer unused and sets deadlines to all
// ones; no clearing pass is needed. Results pass through one output register.
module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int NUM_TIMERS = NumTimersDefault
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic [IdWidth-1:0]   timer_id,
    input  logic [TimeWidth-1:0] deadline,
    input  logic [TimeWidth-1:0] now,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           kind,
    output logic [IdWidth-1:0]   fired_id,
    output logic [TimeWidth-1:0] arm_deadline,
    output logic                 last
);

    localparam int IdxW = $clog2(NUM_TIMERS);

    typedef enum logic {
        S_IDLE,
        S_PROGRESS
    } state_t;

    state_t               state_reg, state_next;
    logic [TimeWidth-1:0] now_reg, now_next;
    logic [TimeWidth-1:0] dl_reg [NUM_TIMERS];
    status_t              st_reg [NUM_TIMERS];

    logic                 ov_reg, ov_next;
    logic [1:0]           kind_reg, kind_next;
    logic [IdWidth-1:0]   fid_reg, fid_next;
    logic [TimeWidth-1:0] nd_reg, nd_next;
    logic                 last_reg, last_next;

    chain_cmd_t           cmd;
    logic                 head_valid;
    logic [IdWidth-1:0]   head_id;
    logic [TimeWidth-1:0] head_key;

    logic                 out_free, in_fire, id_ok, queued;
    logic [IdxW-1:0]      idx;
    logic                 st_we;
    status_t              st_wval;
    logic [IdxW-1:0]      st_widx;
    logic                 dl_we;

    assign out_free = !ov_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;
    assign id_ok    = {{(32-IdWidth){1'b0}}, timer_id} < NUM_TIMERS;
    assign idx      = IdxW'(timer_id);
    assign queued   = id_ok && st_reg[idx] == ST_QUEUED;

    dtq_chain #(.NUM_TIMERS(NUM_TIMERS)) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .head_valid (head_valid),
        .head_id    (head_id),
        .head_key   (head_key)
    );

    always_comb
    begin
        state_next = state_reg;
        now_next   = now_reg;
        ov_next    = ov_reg && !out_ready;
        kind_next  = kind_reg;
        fid_next   = fid_reg;
        nd_next    = nd_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.id     = timer_id;
        cmd.key    = dl_reg[idx];
        st_we      = 1'b0;
        st_wval    = ST_UNUSED;
        st_widx    = idx;
        dl_we      = 1'b0;
        if (state_reg == S_IDLE)
        begin
            if (in_fire)
            begin
                ov_next   = 1'b1;
                kind_next = KIND_ACK;
                fid_next  = timer_id;
                nd_next   = '0;
                last_next = 1'b1;
                if (operation == OP_PROGRESS)
                begin
                    ov_next    = 1'b0;
                    now_next   = now;
                    state_next = S_PROGRESS;
                end
                else if (id_ok)
                begin
                    case (operation)
                        OP_SET:
                        begin
                            dl_we = 1'b1;
                            if (queued)
                            begin
                                cmd.remove = 1'b1;
                                st_we      = 1'b1;
                                st_wval    = ST_CANCELLED;
                            end
                        end
                        OP_INSTALL:
                        begin
                            if (queued)
                                kind_next = KIND_IGNORED;
                            else
                            begin
                                cmd.insert = 1'b1;
                                st_we      = 1'b1;
                                st_wval    = ST_QUEUED;
                            end
                        end
                        default:
                        begin
                            cmd.remove = queued;
                            st_we      = 1'b1;
                            st_wval    = ST_CANCELLED;
                        end
                    endcase
                end
            end
        end
        else if (out_free)
        begin
            ov_next = 1'b1;
            if (head_valid && head_key <= now_reg)
            begin
                cmd.pop   = 1'b1;
                st_we     = 1'b1;
                st_wval   = ST_FIRED;
                st_widx   = IdxW'(head_id);
                kind_next = KIND_FIRED;
                fid_next  = head_id;
                nd_next   = head_key;
                last_next = 1'b0;
            end
            else
            begin
                kind_next  = KIND_ARM;
                fid_next   = '0;
                nd_next    = head_valid ? head_key : '0;
                last_next  = 1'b1;
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                st_reg[i] <= ST_UNUSED;
                dl_reg[i] <= '1;
            end
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (st_we)
                st_reg[st_widx] <= st_wval;
            if (dl_we)
                dl_reg[idx] <= deadline;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        kind_reg <= kind_next;
        fid_reg  <= fid_next;
        nd_reg   <= nd_next;
        last_reg <= last_next;
    end

    assign out_valid    = ov_reg;
    assign kind         = kind_reg;
    assign fired_id     = fid_reg;
    assign arm_deadline = nd_reg;
    assign last         = last_reg;

    a_no_accept_in_progress: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROGRESS |-> !in_ready)
        else $error("input taken during progress");
    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_FIRED |-> !last)
        else $error("fired beat marked last");
    a_arm_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ARM |-> last && fired_id == '0)
        else $error("arm beat malformed");
    a_fired_due: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_FIRED |-> arm_deadline <= now_reg)
        else $error("timer fired before its deadline");

endmodule
